FILE: src/command_line_splitter_macros.svh
// Assertion macros for the command line splitter.
`ifndef COMMAND_LINE_SPLITTER_MACROS_SVH
`define COMMAND_LINE_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cls_pkg.sv
`timescale 1ns / 1ps

package cls_pkg;

   localparam int unsigned MAX_RESULTS = 4;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_X      = 8'h78;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       out_last;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      MODE_START = 5'b00001,
      MODE_ARG   = 5'b00010,
      MODE_GAP   = 5'b00100,
      MODE_SQ    = 5'b01000,
      MODE_DQ    = 5'b10000
   } mode_type;

   typedef enum logic [5:0] {
      PH_NONE = 6'b000001,
      PH_BSL  = 6'b000010,
      PH_HEX0 = 6'b000100,
      PH_HEX1 = 6'b001000,
      PH_OCT1 = 6'b010000,
      PH_OCT2 = 6'b100000
   } phase_type;

endpackage

FILE: src/command_line_splitter.sv
`timescale 1ns / 1ps
// Streaming shell-style command line splitter. One command line byte enters per request, with
// in_last on the final byte, and the block returns argument bytes, an end mark after each
// argument and one closing done or unterminated-quote result per line. A request is decoded in
// the cycle it is accepted into a bank of up to four results, which drains one result per cycle
// into the output register while that register is empty or rsp_ready is high. A request that
// produces at most one result is accepted every cycle under the same condition; one producing more
// stalls the next request until its last result moves out through the single result port.

`include "command_line_splitter_macros.svh"

module command_line_splitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cls_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cls_pkg::rsp_payload_type rsp_payload
);
   import cls_pkg::*;

   mode_type        mode_ff, mode_in;
   phase_type       phase_ff, phase_in;
   logic [7:0]      val_ff, val_in;
   logic            inq_ff, inq_in;

   rsp_payload_type bank_ff [MAX_RESULTS];
   rsp_payload_type bank_in [MAX_RESULTS];
   logic [2:0]      cnt_ff, cnt_in;
   rsp_payload_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   rsp_payload_type res [8];
   logic [2:0]      n;
   logic [2:0]      step_cnt;
   logic            do_plain;
   logic [7:0]      b;
   logic            hex_ok;
   logic [3:0]      hex_v;
   logic            oct_ok;
   logic [7:0]      oct_v;
   logic [7:0]      quote_ch;
   logic            accept;
   logic            move;

   assign b      = req_payload.in_byte;
   assign hex_ok = (b inside {["0":"9"], ["A":"F"], ["a":"f"]});
   assign hex_v  = (b inside {["0":"9"]}) ? b[3:0] : 4'(b[3:0] + 4'd9);
   assign oct_ok = (b inside {["0":"7"]});
   assign oct_v  = {val_ff[4:0], b[2:0]};

   assign move      = (cnt_ff != 3'd0) && (!out_valid_ff || rsp_ready);
   assign req_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && move);
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      val_in   = val_ff;
      inq_in   = inq_ff;
      do_plain = 1'b0;
      n        = '0;
      quote_ch = (mode_ff == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
      for (int i = 0; i < 8; i++) begin
         res[i] = '{out_byte: 8'd0, out_kind: KIND_BYTE, out_last: 1'b0};
      end

      case (phase_ff)
         PH_BSL: begin
            phase_in = PH_NONE;
            case (b)
               "a": begin res[n].out_byte = 8'd7; n = n + 3'd1; end
               "b": begin res[n].out_byte = 8'd8; n = n + 3'd1; end
               "e", "E": begin res[n].out_byte = 8'd27; n = n + 3'd1; end
               "f": begin res[n].out_byte = 8'd12; n = n + 3'd1; end
               "n": begin res[n].out_byte = 8'd10; n = n + 3'd1; end
               "r": begin res[n].out_byte = 8'd13; n = n + 3'd1; end
               "t": begin res[n].out_byte = 8'd9; n = n + 3'd1; end
               "v": begin res[n].out_byte = 8'd11; n = n + 3'd1; end
               CH_BSLASH: begin res[n].out_byte = CH_BSLASH; n = n + 3'd1; end
               "x", "X": begin
                  phase_in = PH_HEX0;
                  val_in   = 8'd0;
               end
               default: begin
                  if (oct_ok) begin
                     phase_in = PH_OCT1;
                     val_in   = {5'd0, b[2:0]};
                  end else begin
                     if (inq_ff) begin
                        res[n].out_byte = CH_BSLASH;
                        n = n + 3'd1;
                     end
                     res[n].out_byte = b;
                     n = n + 3'd1;
                  end
               end
            endcase
         end
         PH_HEX0: begin
            if (hex_ok) begin
               val_in   = {4'd0, hex_v};
               phase_in = PH_HEX1;
            end else begin
               phase_in = PH_NONE;
               if (inq_ff) begin
                  res[n].out_byte = CH_BSLASH;
                  n = n + 3'd1;
               end
               res[n].out_byte = CH_X;
               n = n + 3'd1;
               do_plain = 1'b1;
            end
         end
         PH_HEX1: begin
            phase_in = PH_NONE;
            if (hex_ok) begin
               res[n].out_byte = {val_ff[3:0], hex_v};
               n = n + 3'd1;
            end else begin
               res[n].out_byte = val_ff;
               n = n + 3'd1;
               do_plain = 1'b1;
            end
         end
         PH_OCT1, PH_OCT2: begin
            if (oct_ok) begin
               val_in = oct_v;
               if (phase_ff == PH_OCT1) begin
                  phase_in = PH_OCT2;
               end else begin
                  phase_in = PH_NONE;
                  res[n].out_byte = oct_v;
                  n = n + 3'd1;
               end
            end else begin
               phase_in = PH_NONE;
               res[n].out_byte = val_ff;
               n = n + 3'd1;
               do_plain = 1'b1;
            end
         end
         default: begin
            phase_in = PH_NONE;
            do_plain = 1'b1;
         end
      endcase

      if (do_plain) begin
         if ((mode_ff == MODE_SQ) || (mode_ff == MODE_DQ)) begin
            if (b == quote_ch) begin
               mode_in = MODE_ARG;
            end else if (b == CH_BSLASH) begin
               phase_in = PH_BSL;
               inq_in   = 1'b1;
            end else begin
               res[n].out_byte = b;
               n = n + 3'd1;
            end
         end else if (b == CH_SQUOTE) begin
            mode_in = MODE_SQ;
         end else if (b == CH_DQUOTE) begin
            mode_in = MODE_DQ;
         end else if (b == CH_BSLASH) begin
            phase_in = PH_BSL;
            inq_in   = 1'b0;
            mode_in  = MODE_ARG;
         end else if (b inside {8'd32, [8'd9:8'd13]}) begin
            if (mode_ff == MODE_ARG) begin
               res[n].out_kind = KIND_END;
               n = n + 3'd1;
            end
            mode_in = MODE_GAP;
         end else begin
            res[n].out_byte = b;
            n = n + 3'd1;
            mode_in = MODE_ARG;
         end
      end

      if (req_payload.in_last) begin
         case (phase_in)
            PH_BSL: begin
               res[n].out_byte = CH_BSLASH;
               n = n + 3'd1;
            end
            PH_HEX0: begin
               if (inq_in) begin
                  res[n].out_byte = CH_BSLASH;
                  n = n + 3'd1;
               end
               res[n].out_byte = CH_X;
               n = n + 3'd1;
            end
            PH_HEX1, PH_OCT1, PH_OCT2: begin
               res[n].out_byte = val_in;
               n = n + 3'd1;
            end
            default: begin
            end
         endcase
         if ((mode_in == MODE_SQ) || (mode_in == MODE_DQ)) begin
            res[n].out_kind = KIND_ERR;
            n = n + 3'd1;
         end else begin
            if (mode_in == MODE_ARG) begin
               res[n].out_kind = KIND_END;
               n = n + 3'd1;
            end
            res[n].out_kind = KIND_DONE;
            n = n + 3'd1;
         end
         mode_in  = MODE_START;
         phase_in = PH_NONE;
         val_in   = 8'd0;
         inq_in   = 1'b0;
      end

      step_cnt = (n > 3'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : n;
      if (step_cnt != 3'd0) begin
         res[step_cnt - 3'd1].out_last = 1'b1;
      end
   end

   always_comb begin
      bank_in      = bank_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (move) begin
         out_in       = bank_ff[0];
         out_valid_in = 1'b1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            bank_in[i] = bank_ff[i + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            bank_in[i] = res[i];
         end
         cnt_in = step_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         phase_ff     <= PH_NONE;
         val_ff       <= 8'd0;
         inq_ff       <= 1'b0;
         cnt_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            phase_ff <= phase_in;
            val_ff   <= val_in;
            inq_ff   <= inq_in;
         end
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      out_ff  <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `CLS_ASSERT_NEXT(a_line_end_resets, clock, reset, accept && req_payload.in_last, (mode_ff == MODE_START) && (phase_ff == PH_NONE) && (val_ff == 8'd0), "state not cleared after the final byte of a line")
   `CLS_ASSERT_NEXT(a_results_banked, clock, reset, accept && (step_cnt != 3'd0), cnt_ff != 3'd0, "decoded results were not loaded")
   `CLS_ASSERT_SAME(a_close_is_last, clock, reset, out_valid_ff && ((out_ff.out_kind == KIND_DONE) || (out_ff.out_kind == KIND_ERR)), out_ff.out_last, "closing result is not marked last")
   `CLS_ASSERT_SAME(a_bank_bound, clock, reset, 1'b1, cnt_ff <= 3'(MAX_RESULTS), "result bank count out of range")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import cls_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned IDLE_PERCENT = 21;

   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CTL_BEL    = 8'h07;
   localparam logic [7:0] CTL_BS     = 8'h08;
   localparam logic [7:0] CTL_ESC    = 8'h1B;
   localparam logic [7:0] CTL_FF     = 8'h0C;
   localparam logic [7:0] CTL_LF     = 8'h0A;
   localparam logic [7:0] CTL_CR     = 8'h0D;
   localparam logic [7:0] CTL_HT     = 8'h09;
   localparam logic [7:0] CTL_VT     = 8'h0B;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   command_line_splitter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   mode_type        split_state = MODE_START;
   phase_type       esc_phase = PH_NONE;
   logic [7:0]      esc_value = '0;
   logic            esc_quoted = 1'b0;
   rsp_payload_type step_results[$];
   rsp_payload_type expected_results[$];
   rsp_payload_type oldest_expected;
   logic [7:0]      line_text[$];

   bit idle_on = 1'b1;
   int cycle_count = 0;
   int sent_count = 0;
   int line_count = 0;
   int result_count = 0;
   int arg_end_count = 0;
   int quote_error_count = 0;
   int error_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void add_char(logic [7:0] c);
      line_text.insert(line_text.size(), c);
   endfunction

   function automatic void add_result(logic [1:0] kind, logic [7:0] b);
      rsp_payload_type r;
      if (step_results.size() < MAX_RESULTS) begin
         r.out_byte = (kind == KIND_BYTE) ? b : 8'h00;
         r.out_kind = kind;
         r.out_last = 1'b0;
         step_results.insert(step_results.size(), r);
      end
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CTL_CR);
   endfunction

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      return -1;
   endfunction

   function automatic bit is_octal(logic [7:0] b);
      return b >= "0" && b <= "7";
   endfunction

   function automatic void bare_x();
      if (esc_quoted) add_result(KIND_BYTE, CH_BSLASH);
      add_result(KIND_BYTE, CH_X);
   endfunction

   function automatic void plain_byte(logic [7:0] b);
      logic [7:0] closing;
      if (split_state == MODE_SQ || split_state == MODE_DQ) begin
         closing = (split_state == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
         if (b == closing) begin
            split_state = MODE_ARG;
         end else if (b == CH_BSLASH) begin
            esc_phase = PH_BSL;
            esc_quoted = 1'b1;
         end else begin
            add_result(KIND_BYTE, b);
         end
      end else if (b == CH_SQUOTE) begin
         split_state = MODE_SQ;
      end else if (b == CH_DQUOTE) begin
         split_state = MODE_DQ;
      end else if (b == CH_BSLASH) begin
         esc_phase = PH_BSL;
         esc_quoted = 1'b0;
         split_state = MODE_ARG;
      end else if (is_blank(b)) begin
         if (split_state == MODE_ARG) add_result(KIND_END, 8'h00);
         split_state = MODE_GAP;
      end else begin
         add_result(KIND_BYTE, b);
         split_state = MODE_ARG;
      end
   endfunction

   function automatic void escape_code(logic [7:0] e);
      esc_phase = PH_NONE;
      case (e)
         "a": add_result(KIND_BYTE, CTL_BEL);
         "b": add_result(KIND_BYTE, CTL_BS);
         "e", "E": add_result(KIND_BYTE, CTL_ESC);
         "f": add_result(KIND_BYTE, CTL_FF);
         "n": add_result(KIND_BYTE, CTL_LF);
         "r": add_result(KIND_BYTE, CTL_CR);
         "t": add_result(KIND_BYTE, CTL_HT);
         "v": add_result(KIND_BYTE, CTL_VT);
         CH_BSLASH: add_result(KIND_BYTE, CH_BSLASH);
         CH_X, CH_UPPER_X: begin
            esc_phase = PH_HEX0;
            esc_value = 8'h00;
         end
         default: begin
            if (is_octal(e)) begin
               esc_phase = PH_OCT1;
               esc_value = e - CH_ZERO;
            end else begin
               if (esc_quoted) add_result(KIND_BYTE, CH_BSLASH);
               add_result(KIND_BYTE, e);
            end
         end
      endcase
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int h;
      h = hex_value(b);
      case (esc_phase)
         PH_BSL: escape_code(b);
         PH_HEX0: begin
            if (h >= 0) begin
               esc_value = 8'(h);
               esc_phase = PH_HEX1;
            end else begin
               esc_phase = PH_NONE;
               bare_x();
               plain_byte(b);
            end
         end
         PH_HEX1: begin
            esc_phase = PH_NONE;
            if (h >= 0) begin
               add_result(KIND_BYTE, 8'((esc_value << 4) + h));
            end else begin
               add_result(KIND_BYTE, esc_value);
               plain_byte(b);
            end
         end
         PH_OCT1, PH_OCT2: begin
            if (is_octal(b)) begin
               esc_value = 8'((esc_value << 3) + (b - CH_ZERO));
               if (esc_phase == PH_OCT1) begin
                  esc_phase = PH_OCT2;
               end else begin
                  esc_phase = PH_NONE;
                  add_result(KIND_BYTE, esc_value);
               end
            end else begin
               esc_phase = PH_NONE;
               add_result(KIND_BYTE, esc_value);
               plain_byte(b);
            end
         end
         default: begin
            esc_phase = PH_NONE;
            plain_byte(b);
         end
      endcase
   endfunction

   function automatic void close_line();
      case (esc_phase)
         PH_BSL: add_result(KIND_BYTE, CH_BSLASH);
         PH_HEX0: bare_x();
         PH_HEX1, PH_OCT1, PH_OCT2: add_result(KIND_BYTE, esc_value);
         default: ;
      endcase
      if (split_state == MODE_SQ || split_state == MODE_DQ) begin
         add_result(KIND_ERR, 8'h00);
      end else begin
         if (split_state == MODE_ARG) add_result(KIND_END, 8'h00);
         add_result(KIND_DONE, 8'h00);
      end
      split_state = MODE_START;
      esc_phase = PH_NONE;
      esc_value = 8'h00;
      esc_quoted = 1'b0;
   endfunction

   function automatic void split_byte(req_payload_type r);
      step_results.delete();
      take_byte(r.in_byte);
      if (r.in_last) close_line();
      if (step_results.size() > 0) step_results[step_results.size() - 1].out_last = 1'b1;
      foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
   endfunction

   task automatic send_request(input logic [7:0] b, input logic last);
      req_payload_type r;
      r.in_byte = b;
      r.in_last = last;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      split_byte(r);
      sent_count++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_text.size(); i++) begin
         send_request(line_text[i], i == line_text.size() - 1);
      end
      line_count++;
   endtask

   task automatic send_text(input string s);
      line_text.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      send_line();
   endtask

   function automatic logic [7:0] word_char();
      string pool = "abcdefnqxz0123456789";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   task automatic append_escape();
      string named_codes = "abeEfnrtv\\";
      string hex_digits = "0123456789abcdefABCDEF";
      int digits;
      add_char(CH_BSLASH);
      case ($urandom_range(0, 3))
         0: add_char(named_codes[$urandom_range(0, named_codes.len() - 1)]);
         1: begin
            add_char($urandom_range(0, 1) ? CH_X : CH_UPPER_X);
            digits = $urandom_range(0, 2);
            repeat (digits) add_char(hex_digits[$urandom_range(0, 21)]);
         end
         2: begin
            digits = $urandom_range(1, 3);
            repeat (digits) add_char(CH_ZERO + 8'($urandom_range(0, 7)));
         end
         default: add_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic append_blank();
      add_char($urandom_range(0, 5) == 0 ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
   endtask

   task automatic compose_line();
      int tokens;
      int inner;
      logic [7:0] quote;
      line_text.delete();
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 4)) add_char(word_char());
            3: repeat ($urandom_range(1, 2)) append_blank();
            4: begin
               quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
               add_char(quote);
               inner = $urandom_range(0, 3);
               repeat (inner) begin
                  case ($urandom_range(0, 3))
                     0: add_char(word_char());
                     1: append_blank();
                     2: add_char(quote == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                     default: append_escape();
                  endcase
               end
               if ($urandom_range(0, 9) != 0) add_char(quote);
            end
            5, 6, 7: append_escape();
            8: add_char(8'($urandom_range(0, 255)));
            default: add_char($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
         endcase
      end
   endtask

   task automatic test_directed_lines();
      send_text("a b");
      send_text("'' \"");
      send_text("\\");
      send_text("\\xg");
      send_text("\"\\q\\x4");
      send_text("\\3775");
      line_text = '{8'hFF, 8'h00};
      send_line();
   endtask

   task automatic test_random_lines(input int byte_budget);
      int target;
      target = sent_count + byte_budget;
      while (sent_count < target) begin
         compose_line();
         send_line();
      end
   endtask

   task automatic test_streaming_lines(input int byte_budget);
      idle_on = 1'b0;
      test_random_lines(byte_budget);
      idle_on = 1'b1;
   endtask

   task automatic test_noise_lines(input int byte_budget);
      int target;
      target = sent_count + byte_budget;
      while (sent_count < target) begin
         line_text.delete();
         repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(0, 255)));
         send_line();
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (rsp_payload.out_kind == KIND_END) arg_end_count++;
         if (rsp_payload.out_kind == KIND_ERR) quote_error_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result: out_byte %0h, out_kind %0d, out_last %0d",
                   rsp_payload.out_byte, rsp_payload.out_kind, rsp_payload.out_last);
            error_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            if (rsp_payload.out_byte !== oldest_expected.out_byte) begin
               $error("out_byte: expected %0h, got %0h",
                      oldest_expected.out_byte, rsp_payload.out_byte);
               error_count++;
            end
            if (rsp_payload.out_kind !== oldest_expected.out_kind) begin
               $error("out_kind: expected %0d, got %0d",
                      oldest_expected.out_kind, rsp_payload.out_kind);
               error_count++;
            end
            if (rsp_payload.out_last !== oldest_expected.out_last) begin
               $error("out_last: expected %0d, got %0d",
                      oldest_expected.out_last, rsp_payload.out_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lines();
      test_random_lines(200);
      test_streaming_lines(100);
      test_noise_lines(50);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count++;
      end
      $display("Split %0d request bytes across %0d command lines of quotes, escapes and noise.",
               sent_count, line_count);
      $display("Checked %0d results, %0d argument ends and %0d unterminated quote errors.",
               result_count, arg_end_count, quote_error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/cls_pkg.sv
src/command_line_splitter.sv
test/tb.sv
